[rtl/zssenc_pkg.sv]
// Shared types and constants for the zlib stored-block stream encoder.
// Used by the front, queue, back and top-level modules.
package zssenc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [7:0]  BFINAL_1  = 8'h01;
  localparam logic [7:0]  BFINAL_0  = 8'h00;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // One accepted byte plus everything the back end needs to wrap it
  typedef struct packed {
    logic [7:0]  data;
    logic        zhdr;    // stream header precedes the byte
    logic        bhdr;    // stored-block header precedes the byte
    logic        bfinal;
    logic [15:0] size;
    logic        last;    // trailer follows the byte
    logic [15:0] adler_hi;
    logic [15:0] adler_lo;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_CMF,
    ST_FLG,
    ST_BFIN,
    ST_LEN0,
    ST_LEN1,
    ST_NLEN0,
    ST_NLEN1,
    ST_DATA,
    ST_AD0,
    ST_AD1,
    ST_AD2,
    ST_AD3
  } step_e;

endpackage

[rtl/zssenc_front.sv]
// Front end: takes raw bytes, tracks stream/block position and Adler-32,
// and pushes one classified entry per byte. Depends on zssenc_pkg.
module zssenc_front import zssenc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic [7:0]  in_data_i,
  output logic        in_ready_o,
  input  logic        full_i,
  output logic        push_o,
  output q_entry_t    entry_o
);

  logic [31:0] total_length_q;
  logic [31:0] byte_offset_q, byte_offset_d;
  logic [16:0] block_left_q, block_left_d;
  logic [15:0] adler_lo_q, adler_lo_d;
  logic [15:0] adler_hi_q, adler_hi_d;

  logic [32:0] diff;
  logic [31:0] remaining;
  logic        rem_is_one;
  logic        blk_start;
  logic        bfinal;
  logic [15:0] size;
  logic [16:0] lo_sum, hi_sum;
  logic [16:0] lo_red, hi_red;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    diff       = {1'b0, total_length_q} - {1'b0, byte_offset_q};
    // borrow or zero difference: current byte closes the stream
    remaining  = (!diff[32] && (diff[31:0] != 32'd0)) ? diff[31:0] : 32'd1;
    rem_is_one = (remaining == 32'd1);
    blk_start  = (block_left_q == 17'd0);
    bfinal     = (remaining[31:16] == 16'd0);
    size       = bfinal ? remaining[15:0] : BLOCK_MAX;

    lo_sum = {1'b0, adler_lo_q} + {9'd0, in_data_i};
    lo_red = (lo_sum >= ADLER_MOD) ? (lo_sum - ADLER_MOD) : lo_sum;
    hi_sum = {1'b0, adler_hi_q} + lo_red;
    hi_red = (hi_sum >= ADLER_MOD) ? (hi_sum - ADLER_MOD) : hi_sum;

    entry_o.data     = in_data_i;
    entry_o.zhdr     = (byte_offset_q == 32'd0);
    entry_o.bhdr     = blk_start;
    entry_o.bfinal   = bfinal;
    entry_o.size     = size;
    entry_o.last     = rem_is_one;
    entry_o.adler_hi = hi_red[15:0];
    entry_o.adler_lo = lo_red[15:0];

    byte_offset_d = byte_offset_q;
    block_left_d  = block_left_q;
    adler_lo_d    = adler_lo_q;
    adler_hi_d    = adler_hi_q;
    if (push_o) begin
      if (rem_is_one) begin
        byte_offset_d = 32'd0;
        block_left_d  = 17'd0;
        adler_lo_d    = 16'd1;
        adler_hi_d    = 16'd0;
      end else begin
        byte_offset_d = byte_offset_q + 32'd1;
        block_left_d  = blk_start ? ({1'b0, size} - 17'd1) : (block_left_q - 17'd1);
        adler_lo_d    = lo_red[15:0];
        adler_hi_d    = hi_red[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_length_q <= 32'd1;
      byte_offset_q  <= 32'd0;
      block_left_q   <= 17'd0;
      adler_lo_q     <= 16'd1;
      adler_hi_q     <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        total_length_q <= cfg_wdata_i;
      end
      byte_offset_q <= byte_offset_d;
      block_left_q  <= block_left_d;
      adler_lo_q    <= adler_lo_d;
      adler_hi_q    <= adler_hi_d;
    end
  end

  a_adler_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, adler_lo_q} < ADLER_MOD) && ({1'b0, adler_hi_q} < ADLER_MOD))
    else $error("adler halves out of range");

  a_block_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_left_q[16] == 1'b0)
    else $error("block_left exceeds block maximum");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && rem_is_one) |=> (byte_offset_q == 32'd0) && (block_left_q == 17'd0))
    else $error("stream state not restarted after last byte");

endmodule

[rtl/zssenc_fifo.sv]
// Short flop-based queue of classified entries between front and back.
// Depends on zssenc_pkg.
module zssenc_fifo import zssenc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t wdata_i,
  input  logic     pop_i,
  output q_entry_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  q_entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]   count_q;

  assign full_o  = (count_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/zssenc_back.sv]
// Back end: walks the head entry byte by byte (headers, data, trailer)
// into a registered output stage. Depends on zssenc_pkg.
module zssenc_back import zssenc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t head_i,
  input  logic     empty_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic [7:0] out_byte_o,
  output logic     out_run_last_o,
  output logic     out_stream_end_o
);

  step_e      step_q, step_d, cur_step, nxt_step;
  logic       busy_q, busy_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_run_last_q, out_run_last_d;
  logic       out_stream_end_q, out_stream_end_d;
  logic       adv;
  logic       is_last;
  logic [15:0] nsize;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_CMF;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q       <= out_byte_d;
    out_run_last_q   <= out_run_last_d;
    out_stream_end_q <= out_stream_end_d;
  end

  always_comb begin
    nsize = ~head_i.size;
    // a fresh entry starts at its first present section
    if (busy_q) begin
      cur_step = step_q;
    end else if (head_i.zhdr) begin
      cur_step = ST_CMF;
    end else if (head_i.bhdr) begin
      cur_step = ST_BFIN;
    end else begin
      cur_step = ST_DATA;
    end

    case (cur_step)
      ST_CMF:   nxt_step = ST_FLG;
      ST_FLG:   nxt_step = head_i.bhdr ? ST_BFIN : ST_DATA;
      ST_BFIN:  nxt_step = ST_LEN0;
      ST_LEN0:  nxt_step = ST_LEN1;
      ST_LEN1:  nxt_step = ST_NLEN0;
      ST_NLEN0: nxt_step = ST_NLEN1;
      ST_NLEN1: nxt_step = ST_DATA;
      ST_DATA:  nxt_step = ST_AD0;
      ST_AD0:   nxt_step = ST_AD1;
      ST_AD1:   nxt_step = ST_AD2;
      ST_AD2:   nxt_step = ST_AD3;
      default:  nxt_step = ST_CMF;
    endcase

    is_last = (cur_step == ST_AD3) || ((cur_step == ST_DATA) && !head_i.last);
    adv     = !empty_i && (!out_valid_q || out_ready_i);
    pop_o   = adv && is_last;

    step_d = step_q;
    busy_d = busy_q;
    if (adv) begin
      busy_d = !is_last;
      step_d = nxt_step;
    end

    out_valid_d      = out_valid_q;
    out_byte_d       = out_byte_q;
    out_run_last_d   = out_run_last_q;
    out_stream_end_d = out_stream_end_q;
    if (adv) begin
      out_valid_d      = 1'b1;
      out_run_last_d   = is_last;
      out_stream_end_d = (cur_step == ST_AD3);
      case (cur_step)
        ST_CMF:   out_byte_d = ZLIB_CMF;
        ST_FLG:   out_byte_d = ZLIB_FLG;
        ST_BFIN:  out_byte_d = head_i.bfinal ? BFINAL_1 : BFINAL_0;
        ST_LEN0:  out_byte_d = head_i.size[7:0];
        ST_LEN1:  out_byte_d = head_i.size[15:8];
        ST_NLEN0: out_byte_d = nsize[7:0];
        ST_NLEN1: out_byte_d = nsize[15:8];
        ST_DATA:  out_byte_d = head_i.data;
        ST_AD0:   out_byte_d = head_i.adler_hi[15:8];
        ST_AD1:   out_byte_d = head_i.adler_hi[7:0];
        ST_AD2:   out_byte_d = head_i.adler_lo[15:8];
        ST_AD3:   out_byte_d = head_i.adler_lo[7:0];
        default:  out_byte_d = head_i.data;
      endcase
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign out_run_last_o   = out_run_last_q;
  assign out_stream_end_o = out_stream_end_q;

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stream_end_q) |-> out_run_last_q)
    else $error("stream end without run_last");

  a_busy_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !empty_i)
    else $error("sequencer busy with empty queue");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_run_last_q))
    else $error("entry retired without run_last byte");

endmodule

[rtl/zlib_stored_stream_encoder.sv]
// Usage
// Streams raw bytes into a zlib stream built from stored deflate blocks with an
// Adler-32 trailer. Input channel s_axis_*: one raw byte per request in tdata.
// Output channel m_axis_*: one stream byte per request; tlast marks the last
// byte caused by an input byte, tuser marks the final checksum byte.
// cfg_we_i/cfg_wdata_i write total_length (bytes per stream); write it only
// while the block is idle. It is used from the next block header/end test.
// An accepted byte is queued, then registered in the output stage. A plain
// data byte yields one stream byte; the first byte of a stream adds the 2-byte
// zlib header, a block start the 5-byte stored header, the last byte the
// 4-byte Adler-32 trailer. Output runs at one byte per cycle, set by the
// single-byte output register, unless the queue is empty or the receiver stalls.
// Reset: total_length returns to 1, stream state to its start, queue empties.
// The 4-entry queue decouples the two sides. A stalled receiver holds the output
// register; the queue fills and then s_axis_tready drops until space opens again.
// Depends on zssenc_pkg, zssenc_front, zssenc_fifo, zssenc_back.
module zlib_stored_stream_encoder import zssenc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // [0] stream_end
);

  q_entry_t push_entry, head_entry;
  logic     push, pop, full, empty;

  zssenc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  zssenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  zssenc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_entry),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_run_last_o   (m_axis_tlast),
    .out_stream_end_o (m_axis_tuser)
  );

endmodule

[tb/tb_top.sv]
// Self-checking bench for zlib_stored_stream_encoder: directed and random byte requests in,
// each wrapped byte out checked against an in-bench zlib/stored-block/Adler-32 predictor.
// Depends on zssenc_pkg and the encoder RTL.
module tb_top;
  import zssenc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
  } zout_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Predictor state: configured length, stream position, block credit, Adler halves
  logic [31:0] cfg_total;
  logic [31:0] str_offset;
  logic [16:0] blk_left;
  logic [15:0] sum_lo;
  logic [15:0] sum_hi;

  zout_t zbytes_due[$];
  int    mismatches  = 0;
  int    zbytes_seen = 0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  logic  rx_hold = 1'b0;

  zlib_stored_stream_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 2_000_000);
    $display("zlib_stored_stream_encoder test failed");
    $finish;
  end

  function automatic void restart_stream();
    str_offset = '0;
    blk_left   = '0;
    sum_lo     = 16'd1;
    sum_hi     = '0;
  endfunction

  function automatic void push_zbyte(input logic [7:0] d, input logic fin);
    zout_t z;
    z.data       = d;
    z.run_last   = 1'b0;
    z.stream_end = fin;
    zbytes_due.insert(zbytes_due.size(), z);
  endfunction

  // Expected stream bytes caused by one raw byte
  function automatic void wrap_byte(input logic [7:0] b);
    logic [31:0] left;
    logic [15:0] size;
    logic [31:0] acc;
    zout_t       tail;
    // past the configured length the current byte closes the stream
    left = (cfg_total > str_offset) ? cfg_total - str_offset : 32'd1;
    if (str_offset == 0) begin
      push_zbyte(ZLIB_CMF, 1'b0);
      push_zbyte(ZLIB_FLG, 1'b0);
    end
    if (blk_left == 0) begin
      size = (left < 32'(BLOCK_MAX)) ? left[15:0] : BLOCK_MAX;
      push_zbyte((left <= 32'(BLOCK_MAX)) ? BFINAL_1 : BFINAL_0, 1'b0);
      push_zbyte(size[7:0], 1'b0);
      push_zbyte(size[15:8], 1'b0);
      push_zbyte(~size[7:0], 1'b0);
      push_zbyte(~size[15:8], 1'b0);
      blk_left = {1'b0, size};
    end
    push_zbyte(b, 1'b0);
    blk_left   = blk_left - 17'd1;
    str_offset = str_offset + 32'd1;
    acc    = (32'(sum_lo) + 32'(b)) % 32'(ADLER_MOD);
    sum_lo = acc[15:0];
    acc    = (32'(sum_hi) + 32'(sum_lo)) % 32'(ADLER_MOD);
    sum_hi = acc[15:0];
    if (left == 32'd1) begin
      push_zbyte(sum_hi[15:8], 1'b0);
      push_zbyte(sum_hi[7:0], 1'b0);
      push_zbyte(sum_lo[15:8], 1'b0);
      push_zbyte(sum_lo[7:0], 1'b1);
      restart_stream();
    end
    tail = zbytes_due[zbytes_due.size() - 1];
    tail.run_last = 1'b1;
    zbytes_due[zbytes_due.size() - 1] = tail;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR: %s", what);
  endtask

  // Receiver: random stalls, or held off entirely while rx_hold is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Outputs are stable at the falling edge; a request seen here is taken at the next rise
  always @(negedge clk_i) begin
    zout_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (zbytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h at #%0d", m_axis_tdata,
                                  zbytes_seen));
      end else begin
        want = zbytes_due.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("byte #%0d: tdata %02h, want %02h", zbytes_seen,
                                    m_axis_tdata, want.data));
        if (m_axis_tlast !== want.run_last)
          report_mismatch($sformatf("byte #%0d: tlast %b, want %b", zbytes_seen,
                                    m_axis_tlast, want.run_last));
        if (m_axis_tuser !== want.stream_end)
          report_mismatch($sformatf("byte #%0d: tuser %b, want %b", zbytes_seen,
                                    m_axis_tuser, want.stream_end));
      end
      zbytes_seen++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    logic took;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    wrap_byte(b);
  endtask

  // Sender pauses until every expected byte is out
  task automatic drain_zbytes();
    s_axis_tvalid <= 1'b0;
    while (zbytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_total(input logic [31:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_total  = len;
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // Reset length of one: every byte is a whole stream
  task automatic test_single_byte_streams();
    set_idling(0, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
    drain_zbytes();
  endtask

  task automatic test_short_streams();
    set_total(32'd3);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    drain_zbytes();
    set_total(32'd2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    drain_zbytes();
  endtask

  // Length rewritten mid-stream: the stream closes early with its block unfilled
  task automatic test_midstream_rewrite();
    set_total(32'hFFFF_FFFF);
    repeat (5) send_byte(8'($urandom_range(255)));
    drain_zbytes();
    set_total(32'd3);                    // already past the new length
    send_byte(8'h5A);
    drain_zbytes();
    set_total(32'd10);
    repeat (4) send_byte(8'($urandom_range(255)));
    drain_zbytes();
    set_total(32'd5);                    // exactly one byte left
    send_byte(8'hC3);
    drain_zbytes();
  endtask

  task automatic test_random_phase(input int n_items, input int tx, input int rx);
    int          sent;
    int          chunk;
    logic [31:0] to_end;
    logic [31:0] len;
    set_idling(tx, rx);
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(2) == 0) begin
        len = ($urandom_range(9) == 0) ? 32'($urandom_range(13, 48))
                                       : 32'($urandom_range(1, 12));
        drain_zbytes();
        set_total(len);
      end
      to_end = (cfg_total > str_offset) ? cfg_total - str_offset : 32'd1;
      chunk  = int'(to_end);
      // now and then leave a stream open so the next length lands mid-stream
      if ($urandom_range(7) == 0 && to_end > 1) chunk = $urandom_range(1, int'(to_end) - 1);
      repeat (chunk) send_byte(8'($urandom_range(255)));
      sent += chunk;
    end
    drain_zbytes();
  endtask

  task automatic test_random();
    test_random_phase(75, 0, 0);
    test_random_phase(75, 52, 0);
    test_random_phase(75, 0, 52);
    test_random_phase(75, 15, 15);
  endtask

  // Receiver blocked long enough for the queue to fill and input tready to drop
  task automatic test_backpressure();
    set_idling(0, 0);
    set_total(32'd8);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (24) send_byte(8'($urandom_range(255)));
      end
    join
    drain_zbytes();
  endtask

  initial begin
    cfg_total = 32'd1;
    restart_stream();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_byte_streams();
    test_short_streams();
    test_midstream_rewrite();
    test_random();
    test_backpressure();

    drain_zbytes();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && zbytes_due.size() == 0) begin
      $display("zlib_stored_stream_encoder test passed");
    end else begin
      $display("zlib_stored_stream_encoder test failed");
    end
    $finish;
  end

endmodule

[zlib_stored_stream_encoder.f]
rtl/zssenc_pkg.sv
rtl/zssenc_front.sv
rtl/zssenc_fifo.sv
rtl/zssenc_back.sv
rtl/zlib_stored_stream_encoder.sv
tb/tb_top.sv
